>>> src/flash_log_ring_pointer_manager_top_assert.svh
// ----------------------------------------------------------------------------
// Flash log ring pointer manager assertion macros
// Concurrent assertion helpers for the top level, clocked on clock and
// disabled during reset. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef FLASH_LOG_RING_POINTER_MANAGER_TOP_ASSERT_SVH
`define FLASH_LOG_RING_POINTER_MANAGER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define FLRPM_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("flrpm: same-cycle check failed");
// Next-cycle implication.
`define FLRPM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("flrpm: next-cycle check failed");
`else
`define FLRPM_ASSERT_IMPLY(label, ante, cons)
`define FLRPM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> src/flrpm_pkg.sv
// ----------------------------------------------------------------------------
// Flash log ring pointer manager package
// Shared constants, codes and payload types of the ring pointer manager.
// ----------------------------------------------------------------------------
package flrpm_pkg;

   localparam int MAX_SECTORS      = 512;
   localparam int PAGES_PER_SECTOR = 16;
   localparam int COUNT_MAX        = 8192;

   localparam int SECTOR_W = 9;
   localparam int RING_W   = 10;
   localparam int PAGE_W   = 4;
   localparam int COUNT_W  = 14;
   localparam int LIMIT_W  = 8;
   localparam int NUM_LANES = 3;
   localparam int CNT_W    = $clog2(RING_W);
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // Successor lanes of the recompute unit.
   localparam int LANE_HEAD = 0;
   localparam int LANE_TAIL = 1;
   localparam int LANE_READ = 2;

   typedef enum logic [2:0] {
      MODE_TICK       = 3'd0,
      MODE_APPEND     = 3'd1,
      MODE_CLEAR      = 3'd2,
      MODE_ITER_BEGIN = 3'd3,
      MODE_ITER_NEXT  = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BUSY   = 2'd1,
      ST_REJECT = 2'd2,
      ST_DONE   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CMD_NONE         = 3'd0,
      CMD_SECTOR_ERASE = 3'd1,
      CMD_PROGRAM      = 3'd2,
      CMD_READ         = 3'd3,
      CMD_CHIP_ERASE   = 3'd4
   } command_type;

   typedef enum logic [1:0] {
      PH_NONE   = 2'd0,
      PH_REQ    = 2'd1,
      PH_FLIGHT = 2'd2
   } phase_type;

   typedef enum logic {
      REG_SECTOR_COUNT  = 1'b0,
      REG_PAYLOAD_LIMIT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [7:0]  payload_len;
      logic [7:0]  record_type;
      logic [31:0] timestamp_ms;
      logic        flash_busy;
      logic        erase_accepted;
      logic        program_ok;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [2:0]          command;
      logic [SECTOR_W-1:0] cmd_sector;
      logic [PAGE_W-1:0]   cmd_page;
      logic [31:0]         record_seq;
      logic [31:0]         record_time;
      logic [7:0]          record_len;
      logic [7:0]          record_kind;
      logic [COUNT_W-1:0]  stored_count;
      logic [COUNT_W-1:0]  read_remaining;
   } rsp_type;

   // Request to the successor recompute unit.
   typedef struct packed {
      logic                                start;
      logic [RING_W-1:0]                   ring;
      logic [NUM_LANES-1:0][RING_W-1:0]    num;
   } succ_req_type;

   // Answer of the successor recompute unit.
   typedef struct packed {
      logic                                busy;
      logic                                done;
      logic [NUM_LANES-1:0][SECTOR_W-1:0]  rem;
   } succ_rsp_type;

endpackage

>>> src/flrpm_succ_unit.sv
// ----------------------------------------------------------------------------
// Flash log ring successor recompute unit
// Computes (pointer + 1) mod ring size for three pointers in parallel with a
// restoring remainder, one numerator bit per cycle.
// ----------------------------------------------------------------------------
module flrpm_succ_unit
   import flrpm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  succ_req_type succ_req,
   output succ_rsp_type succ_rsp
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;
   logic [RING_W-1:0]                ring_ff, ring_in;
   logic [NUM_LANES-1:0][RING_W-1:0] num_ff, num_in;
   logic [NUM_LANES-1:0][RING_W-1:0] rem_ff, rem_in;
   logic [NUM_LANES-1:0][RING_W:0]   shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      ring_in = ring_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      for (int i = 0; i < NUM_LANES; i++) begin
         shifted[i] = {rem_ff[i], num_ff[i][RING_W-1]};
      end
      if (succ_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(RING_W - 1);
         ring_in = succ_req.ring;
         num_in  = succ_req.num;
         rem_in  = '0;
      end else if (busy_ff) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            num_in[i] = {num_ff[i][RING_W-2:0], 1'b0};
            if (shifted[i] >= {1'b0, ring_ff}) begin
               rem_in[i] = RING_W'(shifted[i] - {1'b0, ring_ff});
            end else begin
               rem_in[i] = shifted[i][RING_W-1:0];
            end
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      ring_ff <= ring_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
   end

   // An empty ring maps every successor to sector zero.
   always_comb begin
      succ_rsp.busy = busy_ff | done_ff;
      succ_rsp.done = done_ff;
      for (int i = 0; i < NUM_LANES; i++) begin
         if (ring_ff == '0) begin
            succ_rsp.rem[i] = '0;
         end else begin
            succ_rsp.rem[i] = rem_ff[i][SECTOR_W-1:0];
         end
      end
   end

endmodule

>>> src/flash_log_ring_pointer_manager_top.sv
// ----------------------------------------------------------------------------
// Flash log ring pointer manager
// Head, tail, sequence, record count, pre-erase scheduler and read iterator of
// a ring of flash sectors used as a circular log.
// ----------------------------------------------------------------------------
// The block takes one event item per clock cycle while req_ready is high and
// returns exactly one result item for each, in order, from the output
// register. All pointer and scheduler updates happen in a single registered
// pass, so the sustained rate is one item per cycle while req_ready is high.
// Results go through a two-entry output buffer (output register plus skid
// register), so an item is still taken while one result waits on a stalled
// consumer; the buffer holds back input only when both entries are full. The
// block keeps the ring successor of the head, tail and read pointers in
// registers so that no modulo is needed on the event path. A write to the
// sector count register starts a recompute of those successors: req_ready is
// low in the access cycle of such a write and while a bit-serial remainder
// unit works through the ten numerator bits. Writes to payload_limit cost nothing.
// Register map: the sector count at byte address 0, payload_limit at 4; paddr
// bits below bit two are ignored.
// ----------------------------------------------------------------------------
`include "flash_log_ring_pointer_manager_top_assert.svh"

module flash_log_ring_pointer_manager_top
   import flrpm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // Event items
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   // Result items
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   // Configuration port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   // Configuration registers.
   logic [RING_W-1:0]   sector_count_ff;
   logic [LIMIT_W-1:0]  payload_limit_ff;
   logic                csr_write;
   logic                sectors_write;
   logic                recompute_ff;

   // Ring state.
   logic [SECTOR_W-1:0] head_sector_ff, head_sector_in;
   logic [PAGE_W:0]     head_page_ff, head_page_in;
   logic [SECTOR_W-1:0] head_next_ff, head_next_in;
   logic [SECTOR_W-1:0] tail_sector_ff, tail_sector_in;
   logic [SECTOR_W-1:0] tail_next_ff, tail_next_in;
   logic [31:0]         next_sequence_ff, next_sequence_in;
   logic [COUNT_W-1:0]  record_total_ff, record_total_in;
   logic [SECTOR_W-1:0] erase_target_ff, erase_target_in;
   phase_type           erase_phase_ff, erase_phase_in;
   logic [SECTOR_W-1:0] read_sector_ff, read_sector_in;
   logic [SECTOR_W-1:0] read_next_ff, read_next_in;
   logic [PAGE_W-1:0]   read_page_ff, read_page_in;
   logic [COUNT_W-1:0]  read_left_ff, read_left_in;

   // Step logic.
   logic [RING_W-1:0]   ring;
   logic                pump_erase;
   phase_type           pumped_phase;
   logic                blocked;
   logic                accept;
   rsp_type             result;

   // Output buffer.
   logic                out_valid_ff;
   rsp_type             out_data_ff;
   logic                skid_valid_ff;
   rsp_type             skid_data_ff;
   logic                pop;

   // Successor recompute unit.
   succ_req_type        succ_req;
   succ_rsp_type        succ_rsp;

   // Successor of a sector that already lies inside the ring.
   function automatic logic [SECTOR_W-1:0] ring_succ(
      input logic [SECTOR_W-1:0] sector,
      input logic [RING_W-1:0]   size
   );
      logic [RING_W-1:0] bumped;
      bumped = {1'b0, sector} + RING_W'(1);
      if ((size == '0) || (bumped == size)) begin
         return '0;
      end
      return bumped[SECTOR_W-1:0];
   endfunction

   // ------------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------------
   assign csr_pready    = 1'b1;
   assign csr_write     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign sectors_write = csr_write & (reg_index_type'(csr_paddr[2]) == REG_SECTOR_COUNT);

   always_comb begin
      case (reg_index_type'(csr_paddr[2]))
         REG_SECTOR_COUNT:  csr_prdata = CSR_DW'(sector_count_ff);
         REG_PAYLOAD_LIMIT: csr_prdata = CSR_DW'(payload_limit_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_count_ff  <= RING_W'(MAX_SECTORS);
         payload_limit_ff <= LIMIT_W'(240);
         recompute_ff     <= 1'b0;
      end else begin
         recompute_ff <= sectors_write;
         if (csr_write) begin
            case (reg_index_type'(csr_paddr[2]))
               REG_SECTOR_COUNT:  sector_count_ff  <= csr_pwdata[RING_W-1:0];
               REG_PAYLOAD_LIMIT: payload_limit_ff <= csr_pwdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Sector counts above the supported maximum behave as the maximum.
   assign ring = (sector_count_ff > RING_W'(MAX_SECTORS)) ? RING_W'(MAX_SECTORS)
                                                         : sector_count_ff;

   // The recompute starts the cycle after the write, once the new size is in.
   always_comb begin
      succ_req.start           = recompute_ff;
      succ_req.ring            = ring;
      succ_req.num[LANE_HEAD]  = {1'b0, head_sector_ff} + RING_W'(1);
      succ_req.num[LANE_TAIL]  = {1'b0, tail_sector_ff} + RING_W'(1);
      succ_req.num[LANE_READ]  = {1'b0, read_sector_ff} + RING_W'(1);
   end

   flrpm_succ_unit u_succ (
      .clock    (clock),
      .reset    (reset),
      .succ_req (succ_req),
      .succ_rsp (succ_rsp)
   );

   // ------------------------------------------------------------------------
   // Event handshake
   // ------------------------------------------------------------------------
   assign req_ready = ~skid_valid_ff & ~recompute_ff & ~succ_rsp.busy & ~sectors_write;
   assign accept    = req_valid & req_ready;

   // ------------------------------------------------------------------------
   // One event: pump, head advance, program, clear and iteration
   // ------------------------------------------------------------------------
   always_comb begin
      head_sector_in   = head_sector_ff;
      head_page_in     = head_page_ff;
      head_next_in     = head_next_ff;
      tail_sector_in   = tail_sector_ff;
      tail_next_in     = tail_next_ff;
      next_sequence_in = next_sequence_ff;
      record_total_in  = record_total_ff;
      erase_target_in  = erase_target_ff;
      erase_phase_in   = erase_phase_ff;
      read_sector_in   = read_sector_ff;
      read_next_in     = read_next_ff;
      read_page_in     = read_page_ff;
      read_left_in     = read_left_ff;
      result           = '0;
      result.status    = ST_OK;
      result.command   = CMD_NONE;
      blocked          = 1'b0;

      // The erase pump issues a pending erase, or retires one in flight once
      // the device goes idle. It does nothing without a device.
      pump_erase   = (ring != '0) && (erase_phase_ff == PH_REQ);
      pumped_phase = erase_phase_ff;
      if (ring != '0) begin
         if ((erase_phase_ff == PH_REQ) && req_data.erase_accepted) begin
            pumped_phase = PH_FLIGHT;
         end else if ((erase_phase_ff == PH_FLIGHT) && !req_data.flash_busy) begin
            pumped_phase = PH_NONE;
         end
      end

      case (req_data.mode)
         MODE_TICK: begin
            erase_phase_in = pumped_phase;
            if (pump_erase) begin
               result.command    = CMD_SECTOR_ERASE;
               result.cmd_sector = erase_target_ff;
            end
         end
         MODE_APPEND: begin
            if ((req_data.payload_len > payload_limit_ff) || (ring == '0)) begin
               result.status = ST_REJECT;
            end else if (pump_erase) begin
               // The pump owns the device this step; the append must retry.
               erase_phase_in    = pumped_phase;
               result.command    = CMD_SECTOR_ERASE;
               result.cmd_sector = erase_target_ff;
               result.status     = ST_BUSY;
            end else begin
               erase_phase_in = pumped_phase;
               if (head_page_ff >= (PAGE_W + 1)'(PAGES_PER_SECTOR)) begin
                  if ((pumped_phase != PH_NONE) && (erase_target_ff == head_next_ff)) begin
                     // Next sector is still being erased.
                     blocked = 1'b1;
                  end else if ((pumped_phase == PH_NONE) && (head_next_ff != head_sector_ff)) begin
                     // Nothing scheduled yet: ask for the next sector first.
                     erase_target_in = head_next_ff;
                     erase_phase_in  = PH_REQ;
                     blocked         = 1'b1;
                  end else begin
                     head_sector_in = head_next_ff;
                     head_next_in   = ring_succ(head_next_ff, ring);
                     head_page_in   = '0;
                     if (head_next_ff == tail_sector_ff) begin
                        // Head ran onto the tail: the oldest sector is evicted.
                        tail_sector_in = tail_next_ff;
                        tail_next_in   = ring_succ(tail_next_ff, ring);
                        if (record_total_ff >= COUNT_W'(PAGES_PER_SECTOR)) begin
                           record_total_in = record_total_ff - COUNT_W'(PAGES_PER_SECTOR);
                        end
                     end
                     erase_target_in = ring_succ(head_next_ff, ring);
                     erase_phase_in  = PH_REQ;
                  end
               end
               if (blocked || req_data.flash_busy) begin
                  result.status = ST_BUSY;
               end else begin
                  result.command     = CMD_PROGRAM;
                  result.cmd_sector  = head_sector_in;
                  result.cmd_page    = head_page_in[PAGE_W-1:0];
                  result.record_seq  = next_sequence_ff;
                  result.record_time = req_data.timestamp_ms;
                  result.record_len  = req_data.payload_len;
                  result.record_kind = req_data.record_type;
                  if (req_data.program_ok) begin
                     next_sequence_in = next_sequence_ff + 32'd1;
                     head_page_in     = head_page_in + (PAGE_W + 1)'(1);
                     if (record_total_in < COUNT_W'(COUNT_MAX)) begin
                        record_total_in = record_total_in + COUNT_W'(1);
                     end
                  end else begin
                     result.status = ST_BUSY;
                  end
               end
            end
         end
         MODE_CLEAR: begin
            if (req_data.flash_busy) begin
               result.status = ST_BUSY;
            end else begin
               // The sequence number and the read iterator survive a clear.
               result.command  = CMD_CHIP_ERASE;
               head_sector_in  = '0;
               head_page_in    = '0;
               head_next_in    = ring_succ('0, ring);
               tail_sector_in  = '0;
               tail_next_in    = ring_succ('0, ring);
               record_total_in = '0;
               erase_target_in = '0;
               erase_phase_in  = PH_NONE;
            end
         end
         MODE_ITER_BEGIN: begin
            read_sector_in = tail_sector_ff;
            read_next_in   = tail_next_ff;
            read_page_in   = '0;
            read_left_in   = record_total_ff;
         end
         MODE_ITER_NEXT: begin
            if (read_left_ff == '0) begin
               result.status = ST_DONE;
            end else begin
               result.command    = CMD_READ;
               result.cmd_sector = read_sector_ff;
               result.cmd_page   = read_page_ff;
               if (read_page_ff == PAGE_W'(PAGES_PER_SECTOR - 1)) begin
                  read_page_in   = '0;
                  read_sector_in = read_next_ff;
                  read_next_in   = ring_succ(read_next_ff, ring);
               end else begin
                  read_page_in = read_page_ff + PAGE_W'(1);
               end
               read_left_in = read_left_ff - COUNT_W'(1);
            end
         end
         default: begin
            result.status = ST_REJECT;
         end
      endcase

      result.stored_count   = record_total_in;
      result.read_remaining = read_left_in;
   end

   // ------------------------------------------------------------------------
   // State registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         head_sector_ff   <= '0;
         head_page_ff     <= '0;
         head_next_ff     <= SECTOR_W'(1);
         tail_sector_ff   <= '0;
         tail_next_ff     <= SECTOR_W'(1);
         next_sequence_ff <= 32'd1;
         record_total_ff  <= '0;
         erase_target_ff  <= '0;
         erase_phase_ff   <= PH_REQ;
         read_sector_ff   <= '0;
         read_next_ff     <= SECTOR_W'(1);
         read_page_ff     <= '0;
         read_left_ff     <= '0;
      end else if (succ_rsp.done) begin
         // No item is taken while the successors are recomputed.
         head_next_ff <= succ_rsp.rem[LANE_HEAD];
         tail_next_ff <= succ_rsp.rem[LANE_TAIL];
         read_next_ff <= succ_rsp.rem[LANE_READ];
      end else if (accept) begin
         head_sector_ff   <= head_sector_in;
         head_page_ff     <= head_page_in;
         head_next_ff     <= head_next_in;
         tail_sector_ff   <= tail_sector_in;
         tail_next_ff     <= tail_next_in;
         next_sequence_ff <= next_sequence_in;
         record_total_ff  <= record_total_in;
         erase_target_ff  <= erase_target_in;
         erase_phase_ff   <= erase_phase_in;
         read_sector_ff   <= read_sector_in;
         read_next_ff     <= read_next_in;
         read_page_ff     <= read_page_in;
         read_left_ff     <= read_left_in;
      end
   end

   // ------------------------------------------------------------------------
   // Two-entry result buffer. The skid entry fills only when the output
   // register is held by a stalled consumer, and input stops while it is full.
   // ------------------------------------------------------------------------
   assign pop = out_valid_ff & rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= accept;
            end
         end else if (accept) begin
            if (out_valid_ff) begin
               skid_valid_ff <= 1'b1;
            end else begin
               out_valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && skid_valid_ff) begin
         out_data_ff <= skid_data_ff;
      end else if (accept && (pop || !out_valid_ff)) begin
         out_data_ff <= result;
      end
      if (accept && out_valid_ff && !pop) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `FLRPM_ASSERT_IMPLY(a_skid_behind_output, skid_valid_ff, out_valid_ff)
   `FLRPM_ASSERT_IMPLY(a_no_item_during_recompute, succ_rsp.busy, !req_ready)
   `FLRPM_ASSERT_IMPLY(a_head_page_bound, 1'b1, head_page_ff <= (PAGE_W + 1)'(PAGES_PER_SECTOR))
   `FLRPM_ASSERT_NEXT(a_clear_empties_log, accept && (req_data.mode == MODE_CLEAR) && !req_data.flash_busy, (record_total_ff == '0) && (erase_phase_ff == PH_NONE))

endmodule
